### design/bcfg_pkg.sv
`timescale 1ns / 1ps

package bcfg_pkg;

  // field and state widths
  localparam int CUR_W     = 16;                  // current sample width
  localparam int FRAC_W    = 38;                  // fraction bits of the charge level
  localparam int CHG_W     = FRAC_W + 2;          // signed Q2.FRAC_W
  localparam int SUM_W     = CUR_W + 1;           // current + last current
  localparam int MAG_W     = SUM_W;               // magnitude of the sum
  localparam int CAP_W     = 16;
  localparam int INIT_W    = 17;
  localparam int TICK_DIV  = 7200;                // two times seconds per hour
  localparam int TICK_W    = 13;                  // bits of TICK_DIV
  localparam int DIV_W     = CAP_W + TICK_W;      // divisor width
  // quotient never exceeds CUR_W + FRAC_W - 12 bits, and must hold the step limit
  localparam int QUO_W     = (CUR_W + FRAC_W - 12 > FRAC_W + 3) ?
                             CUR_W + FRAC_W - 12 : FRAC_W + 3;
  localparam int DIV_STEPS = MAG_W + FRAC_W;      // one quotient bit per step
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int UPD_W     = CHG_W + 2;           // headroom for the update
  localparam int SOC_SHIFT = FRAC_W - 16;
  localparam int S_W       = CHG_W - SOC_SHIFT;   // signed Q2.16 charge
  localparam int ACC_W     = 32;                  // horner accumulator
  localparam int PROD_W    = ACC_W + S_W;
  localparam int PC_W      = 5;

  // output fields
  localparam int SOC_W = 17;
  localparam int VOC_W = 23;
  localparam int RES_W = 20;
  localparam int VOC_MAX  = 5000000;
  localparam int RES_MAX  = 1000000;
  localparam int SOC_FULL = 65536;
  localparam int SOC_PCT1 = 655;                  // floor of 0.01 in Q0.16

  // configuration registers and their default values
  localparam int CAP_RESET  = 3200;
  localparam int INIT_RESET = 65536;
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_INIT_SOC = 1'b1;

  localparam logic [QUO_W-1:0] DELTA_CAP = QUO_W'(1) << (FRAC_W + 2);
  localparam logic signed [UPD_W-1:0] UPD_ONE   = UPD_W'(1) << FRAC_W;
  localparam logic signed [UPD_W-1:0] UPD_FLOOR = -(UPD_W'(2) << FRAC_W);
  localparam logic [63:0] SOC_ONE_U  = 64'd1 << FRAC_W;
  localparam logic [63:0] DEPL_LIMIT = SOC_ONE_U / 100;

  // coefficient selectors
  localparam logic [2:0] C_VOC0 = 3'd0;
  localparam logic [2:0] C_VOC1 = 3'd1;
  localparam logic [2:0] C_VOC2 = 3'd2;
  localparam logic [2:0] C_VOC3 = 3'd3;
  localparam logic [2:0] C_RES0 = 3'd4;
  localparam logic [2:0] C_RES1 = 3'd5;
  localparam logic [2:0] C_RES2 = 3'd6;
  localparam logic [2:0] C_RES3 = 3'd7;

  typedef enum logic [2:0] {
    OP_SETUP  = 3'd0,
    OP_DIV    = 3'd1,
    OP_UPDATE = 3'd2,
    OP_SCALE  = 3'd3,
    OP_MUL    = 3'd4,
    OP_ADD    = 3'd5,
    OP_SAVEV  = 3'd6,
    OP_EMIT   = 3'd7
  } op_t;

  typedef enum logic {
    JC_NEXT = 1'b0,
    JC_LOOP = 1'b1
  } jc_t;

  typedef struct packed {
    op_t              op;
    logic [2:0]       csel;
    jc_t              jc;
    logic [PC_W-1:0]  target;
  } uword_t;

  localparam logic [PC_W-1:0] PC_DIV = PC_W'(1);

  // horner coefficients, microvolts and nano-ohms
  function automatic logic signed [ACC_W-1:0] coef(input logic [2:0] sel);
    logic signed [ACC_W-1:0] c;
    case (sel)
      C_VOC0:  c = ACC_W'(2622000);
      C_VOC1:  c = ACC_W'(3154000);
      C_VOC2:  c = -ACC_W'(4232000);
      C_VOC3:  c = ACC_W'(2419000);
      C_RES0:  c = ACC_W'(20540);
      C_RES1:  c = ACC_W'(337200);
      C_RES2:  c = -ACC_W'(642300);
      C_RES3:  c = ACC_W'(337100);
      default: c = '0;
    endcase
    return c;
  endfunction

  // control store
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_EMIT, csel: C_VOC0, jc: JC_NEXT, target: '0};
    case (pc)
      5'd0:    w = '{op: OP_SETUP,  csel: C_VOC0, jc: JC_NEXT, target: '0};
      5'd1:    w = '{op: OP_DIV,    csel: C_VOC0, jc: JC_LOOP, target: PC_DIV};
      5'd2:    w = '{op: OP_UPDATE, csel: C_VOC0, jc: JC_NEXT, target: '0};
      5'd3:    w = '{op: OP_SCALE,  csel: C_VOC3, jc: JC_NEXT, target: '0};
      5'd4:    w = '{op: OP_MUL,    csel: C_VOC0, jc: JC_NEXT, target: '0};
      5'd5:    w = '{op: OP_ADD,    csel: C_VOC2, jc: JC_NEXT, target: '0};
      5'd6:    w = '{op: OP_MUL,    csel: C_VOC0, jc: JC_NEXT, target: '0};
      5'd7:    w = '{op: OP_ADD,    csel: C_VOC1, jc: JC_NEXT, target: '0};
      5'd8:    w = '{op: OP_MUL,    csel: C_VOC0, jc: JC_NEXT, target: '0};
      5'd9:    w = '{op: OP_ADD,    csel: C_VOC0, jc: JC_NEXT, target: '0};
      5'd10:   w = '{op: OP_SAVEV,  csel: C_RES3, jc: JC_NEXT, target: '0};
      5'd11:   w = '{op: OP_MUL,    csel: C_VOC0, jc: JC_NEXT, target: '0};
      5'd12:   w = '{op: OP_ADD,    csel: C_RES2, jc: JC_NEXT, target: '0};
      5'd13:   w = '{op: OP_MUL,    csel: C_VOC0, jc: JC_NEXT, target: '0};
      5'd14:   w = '{op: OP_ADD,    csel: C_RES1, jc: JC_NEXT, target: '0};
      5'd15:   w = '{op: OP_MUL,    csel: C_VOC0, jc: JC_NEXT, target: '0};
      5'd16:   w = '{op: OP_ADD,    csel: C_RES0, jc: JC_NEXT, target: '0};
      5'd17:   w = '{op: OP_EMIT,   csel: C_VOC0, jc: JC_NEXT, target: '0};
      default: w = '{op: OP_EMIT,   csel: C_VOC0, jc: JC_NEXT, target: '0};
    endcase
    return w;
  endfunction

endpackage

### design/battery_coulomb_fuel_gauge.sv
`timescale 1ns / 1ps

// coulomb-counting fuel gauge, one input word per one-second tick
// input channel: in_valid / in_stall carry in_current_ma (signed mA, positive
//   discharges). a word is taken when in_valid is high and in_stall low.
// result channel: out_valid / out_stall carry one word per input word: state
//   of charge (Q1.16), open-circuit voltage (uV), series resistance (nOhm)
//   and a depleted flag for a charge at or below one percent
// configuration: apb-style port, capacity_mah at 0x0, initial_soc at 0x4;
//   writing initial_soc reloads the charge level at once. pready is always
//   high; only write while no word is in flight
// timing: one word in flight at a time; the sequencer runs setup, the divide
//   loop, the charge update, scaling, the voltage cubic, the resistance cubic
//   and emit. the trapezoid divide is a restoring divider giving one quotient
//   bit per cycle, and the two cubics share one multiplier
// input: a new word is taken once the previous result is in the output register
// stall: a finished result waits in the output register; the next word can
//   already be taken and worked on, and the sequencer holds at its last step
//   only when a second result is ready before the first has left
// reset: capacity 3200 mAh, full charge, last current zero, no result held
module battery_coulomb_fuel_gauge (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [bcfg_pkg::CUR_W-1:0] in_current_ma,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bcfg_pkg::SOC_W-1:0]      out_soc_out,
  output logic [bcfg_pkg::VOC_W-1:0]      out_open_voltage_uv,
  output logic [bcfg_pkg::RES_W-1:0]      out_series_res_nohm,
  output logic                            out_depleted,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // configuration
  logic [bcfg_pkg::CAP_W-1:0]  cap_r;
  logic [bcfg_pkg::INIT_W-1:0] init_r;

  // sequencer
  logic                        busy_r, busy_nxt;
  logic [bcfg_pkg::PC_W-1:0]   pc_r, pc_nxt;
  bcfg_pkg::uword_t            uw;

  // datapath
  logic signed [bcfg_pkg::CUR_W-1:0]  cur_r, cur_nxt;
  logic signed [bcfg_pkg::CUR_W-1:0]  last_r, last_nxt;
  logic                               neg_r, neg_nxt;
  logic [bcfg_pkg::MAG_W-1:0]         mag_r, mag_nxt;
  logic [bcfg_pkg::DIV_W-1:0]         div_r, div_nxt;
  logic [bcfg_pkg::DIV_W-1:0]         rem_r, rem_nxt;
  logic [bcfg_pkg::QUO_W-1:0]         quo_r, quo_nxt;
  logic [bcfg_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [bcfg_pkg::CHG_W-1:0]  chg_r, chg_nxt;
  logic signed [bcfg_pkg::S_W-1:0]    s_r, s_nxt;
  logic signed [bcfg_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [bcfg_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [bcfg_pkg::VOC_W-1:0]         voc_r, voc_nxt;

  // output register
  logic                               ovld_r, ovld_nxt;
  logic [bcfg_pkg::SOC_W-1:0]         osoc_r, osoc_nxt;
  logic [bcfg_pkg::VOC_W-1:0]         ovoc_r, ovoc_nxt;
  logic [bcfg_pkg::RES_W-1:0]         ores_r, ores_nxt;
  logic                               odepl_r, odepl_nxt;

  // helpers
  logic                               cfg_wr;
  logic                               in_acc;
  logic                               emit_go;
  logic [bcfg_pkg::CAP_W-1:0]         cap_eff;
  logic signed [bcfg_pkg::SUM_W-1:0]  sum;
  logic [bcfg_pkg::DIV_W:0]           rem_sh;
  logic                               q_bit;
  logic [bcfg_pkg::QUO_W-1:0]         q_sat;
  logic signed [bcfg_pkg::UPD_W-1:0]  upd;
  logic signed [bcfg_pkg::PROD_W-1:0] prod_rnd;
  logic signed [bcfg_pkg::ACC_W-1:0]  horner;
  logic [bcfg_pkg::INIT_W-1:0]        init_clip;
  logic [bcfg_pkg::INIT_W-1:0]        wr_init;
  logic [bcfg_pkg::INIT_W-1:0]        load_val;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == bcfg_pkg::REG_INIT_SOC) ?
                   32'(init_r) : 32'(cap_r);

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !in_stall;
  assign uw       = bcfg_pkg::ucode(pc_r);
  assign emit_go  = busy_r && (uw.op == bcfg_pkg::OP_EMIT) && (!ovld_r || !out_stall);

  assign out_valid           = ovld_r;
  assign out_soc_out         = osoc_r;
  assign out_open_voltage_uv = ovoc_r;
  assign out_series_res_nohm = ores_r;
  assign out_depleted        = odepl_r;

  // zero capacity behaves as one mAh
  assign cap_eff = (cap_r == '0) ? bcfg_pkg::CAP_W'(1) : cap_r;
  assign sum     = bcfg_pkg::SUM_W'(cur_r) + bcfg_pkg::SUM_W'(last_r);

  // restoring divide, one bit per cycle
  assign rem_sh = {rem_r, mag_r[bcfg_pkg::MAG_W-1]};
  assign q_bit  = rem_sh >= {1'b0, div_r};

  assign q_sat = (quo_r > bcfg_pkg::DELTA_CAP) ? bcfg_pkg::DELTA_CAP : quo_r;
  assign upd   = neg_r ? bcfg_pkg::UPD_W'(chg_r) + bcfg_pkg::UPD_W'(q_sat)
                       : bcfg_pkg::UPD_W'(chg_r) - bcfg_pkg::UPD_W'(q_sat);

  // round to nearest 1/65536, ties up, then floor shift
  assign prod_rnd = prod_r + bcfg_pkg::PROD_W'(32768);
  assign horner   = bcfg_pkg::coef(uw.csel) + bcfg_pkg::ACC_W'(prod_rnd >>> 16);

  // initial charge, saturated at full
  assign wr_init   = pwdata[bcfg_pkg::INIT_W-1:0];
  assign load_val  = (wr_init > bcfg_pkg::INIT_W'(bcfg_pkg::SOC_FULL)) ?
                     bcfg_pkg::INIT_W'(bcfg_pkg::SOC_FULL) : wr_init;
  assign init_clip = load_val;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    cur_nxt  = cur_r;
    last_nxt = last_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    chg_nxt  = chg_r;
    s_nxt    = s_r;
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    voc_nxt  = voc_r;
    ovld_nxt  = ovld_r && out_stall;
    osoc_nxt  = osoc_r;
    ovoc_nxt  = ovoc_r;
    ores_nxt  = ores_r;
    odepl_nxt = odepl_r;

    if (in_acc) begin
      cur_nxt  = in_current_ma;
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end

    if (busy_r) begin
      pc_nxt = pc_r + bcfg_pkg::PC_W'(1);
      case (uw.op)
        bcfg_pkg::OP_SETUP: begin
          last_nxt = cur_r;
          neg_nxt  = sum[bcfg_pkg::SUM_W-1];
          mag_nxt  = sum[bcfg_pkg::SUM_W-1] ? bcfg_pkg::MAG_W'(-sum) : bcfg_pkg::MAG_W'(sum);
          div_nxt  = bcfg_pkg::DIV_W'(cap_eff) * bcfg_pkg::DIV_W'(bcfg_pkg::TICK_DIV);
          rem_nxt  = '0;
          quo_nxt  = '0;
          cnt_nxt  = bcfg_pkg::CNT_W'(bcfg_pkg::DIV_STEPS - 1);
        end
        bcfg_pkg::OP_DIV: begin
          rem_nxt = q_bit ? bcfg_pkg::DIV_W'(rem_sh - {1'b0, div_r})
                          : rem_sh[bcfg_pkg::DIV_W-1:0];
          quo_nxt = {quo_r[bcfg_pkg::QUO_W-2:0], q_bit};
          mag_nxt = {mag_r[bcfg_pkg::MAG_W-2:0], 1'b0};
          cnt_nxt = cnt_r - bcfg_pkg::CNT_W'(1);
        end
        bcfg_pkg::OP_UPDATE: begin
          if (upd < bcfg_pkg::UPD_FLOOR) begin
            chg_nxt = bcfg_pkg::CHG_W'(bcfg_pkg::UPD_FLOOR);
          end else if (upd > bcfg_pkg::UPD_ONE) begin
            chg_nxt = bcfg_pkg::CHG_W'(bcfg_pkg::UPD_ONE);
          end else begin
            chg_nxt = bcfg_pkg::CHG_W'(upd);
          end
        end
        bcfg_pkg::OP_SCALE: begin
          s_nxt   = chg_r[bcfg_pkg::CHG_W-1:bcfg_pkg::SOC_SHIFT];
          acc_nxt = bcfg_pkg::coef(uw.csel);
        end
        bcfg_pkg::OP_MUL: begin
          prod_nxt = bcfg_pkg::PROD_W'(acc_r) * bcfg_pkg::PROD_W'(s_r);
        end
        bcfg_pkg::OP_ADD: begin
          acc_nxt = horner;
        end
        bcfg_pkg::OP_SAVEV: begin
          if (acc_r < 0) begin
            voc_nxt = '0;
          end else if (acc_r > bcfg_pkg::ACC_W'(bcfg_pkg::VOC_MAX)) begin
            voc_nxt = bcfg_pkg::VOC_W'(bcfg_pkg::VOC_MAX);
          end else begin
            voc_nxt = acc_r[bcfg_pkg::VOC_W-1:0];
          end
          acc_nxt = bcfg_pkg::coef(uw.csel);
        end
        bcfg_pkg::OP_EMIT: begin
          if (emit_go) begin
            busy_nxt = 1'b0;
            pc_nxt   = '0;
            ovld_nxt = 1'b1;
            osoc_nxt = s_r[bcfg_pkg::S_W-1] ? '0 : s_r[bcfg_pkg::SOC_W-1:0];
            ovoc_nxt = voc_r;
            if (acc_r < 0) begin
              ores_nxt = '0;
            end else if (acc_r > bcfg_pkg::ACC_W'(bcfg_pkg::RES_MAX)) begin
              ores_nxt = bcfg_pkg::RES_W'(bcfg_pkg::RES_MAX);
            end else begin
              ores_nxt = acc_r[bcfg_pkg::RES_W-1:0];
            end
            odepl_nxt = $signed({chg_r[bcfg_pkg::CHG_W-1], chg_r}) <=
                        $signed({1'b0, bcfg_pkg::DEPL_LIMIT[bcfg_pkg::CHG_W-1:0]});
          end else begin
            pc_nxt = pc_r;
          end
        end
        default: begin
          pc_nxt = pc_r;
        end
      endcase
      // loop back while quotient bits remain
      if (uw.jc == bcfg_pkg::JC_LOOP && cnt_r != '0) begin
        pc_nxt = uw.target;
      end
    end

    // a write to initial_soc reloads the charge level
    if (cfg_wr && paddr[2] == bcfg_pkg::REG_INIT_SOC) begin
      chg_nxt = bcfg_pkg::CHG_W'(init_clip) << bcfg_pkg::SOC_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= bcfg_pkg::CAP_W'(bcfg_pkg::CAP_RESET);
      init_r  <= bcfg_pkg::INIT_W'(bcfg_pkg::INIT_RESET);
      chg_r   <= bcfg_pkg::CHG_W'(bcfg_pkg::INIT_RESET) << bcfg_pkg::SOC_SHIFT;
      last_r  <= '0;
      busy_r  <= 1'b0;
      pc_r    <= '0;
      ovld_r  <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == bcfg_pkg::REG_CAPACITY) begin
        cap_r <= pwdata[bcfg_pkg::CAP_W-1:0];
      end
      if (cfg_wr && paddr[2] == bcfg_pkg::REG_INIT_SOC) begin
        init_r <= wr_init;
      end
      chg_r   <= chg_nxt;
      last_r  <= last_nxt;
      busy_r  <= busy_nxt;
      pc_r    <= pc_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    s_r     <= s_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    voc_r   <= voc_nxt;
    osoc_r  <= osoc_nxt;
    ovoc_r  <= ovoc_nxt;
    ores_r  <= ores_nxt;
    odepl_r <= odepl_nxt;
  end

endmodule

### design/bcfg_checker.sv
`timescale 1ns / 1ps

module bcfg_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [bcfg_pkg::SOC_W-1:0]        out_soc_out,
  input logic [bcfg_pkg::VOC_W-1:0]        out_open_voltage_uv,
  input logic [bcfg_pkg::RES_W-1:0]        out_series_res_nohm,
  input logic                              out_depleted
);

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_soc_out) &&
    $stable(out_open_voltage_uv) && $stable(out_series_res_nohm) && $stable(out_depleted))
    else $error("result word changed while stalled");

  // one word in flight: an accepted word closes the input
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after acceptance");

  // fit outputs and charge stay within their ranges
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_soc_out <= bcfg_pkg::SOC_W'(bcfg_pkg::SOC_FULL) &&
    out_open_voltage_uv <= bcfg_pkg::VOC_W'(bcfg_pkg::VOC_MAX) &&
    out_series_res_nohm <= bcfg_pkg::RES_W'(bcfg_pkg::RES_MAX))
    else $error("result field out of range");

  // depleted flag agrees with the reported charge
  a_depl_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_depleted |-> out_soc_out <= bcfg_pkg::SOC_W'(bcfg_pkg::SOC_PCT1))
    else $error("depleted with charge above one percent");

  a_depl_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_soc_out > bcfg_pkg::SOC_W'(bcfg_pkg::SOC_PCT1) |-> !out_depleted)
    else $error("charge above one percent flagged depleted");

endmodule

bind battery_coulomb_fuel_gauge bcfg_checker u_bcfg_checker (.*);
